FILE: rtl/tsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transient shaper band package
// Shared widths, constants, register indexes, sequencer states and the
// control word handed from the sequencer to the lanes, the merge and the gain path.
// ----------------------------------------------------------------------------
package tsb_pkg;

	localparam int CHANNELS_DEF = 2;
	localparam int IN_LANES     = 2;

	localparam logic [23:0] UNITY_GAIN = 24'd524288;
	localparam logic [23:0] SAMPLE_MAX = 24'h7FFFFF;
	localparam logic [23:0] SAMPLE_MIN = 24'h800000;
	localparam logic [23:0] GAIN_MAX   = 24'hFFFFFF;
	localparam logic [23:0] HALF_SCALE = 24'h800000;

	typedef enum logic [3:0] {
		REG_CHANNELS_IN_USE   = 4'd0,
		REG_TRANSIENT_GAIN    = 4'd1,
		REG_SUSTAIN_GAIN      = 4'd2,
		REG_FAST_ATTACK_COEF  = 4'd3,
		REG_FAST_RELEASE_COEF = 4'd4,
		REG_SLOW_ATTACK_COEF  = 4'd5,
		REG_SLOW_RELEASE_COEF = 4'd6,
		REG_SMOOTHING_COEF    = 4'd7
	} tsb_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENV_MUL,
		ST_ENV_UPD,
		ST_MAX,
		ST_MIX,
		ST_TGT,
		ST_SMOOTH,
		ST_OUT_MUL,
		ST_OUT_SAT
	} tsb_state_t;

	typedef struct packed {
		logic env_mul;
		logic env_upd;
		logic t_load;
		logic mix;
		logic tgt;
		logic smooth;
		logic out_mul;
	} tsb_ctrl_t;

	typedef struct packed {
		logic [23:0] atk;
		logic [23:0] rls;
	} tsb_env_coef_t;

endpackage
`default_nettype wire

FILE: rtl/tsb_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transient shaper band channels
// Valid/ready channels for input frames, result words and register writes.
// ----------------------------------------------------------------------------
interface tsb_in_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] sample_ch0;
	logic signed [23:0] sample_ch1;
	modport source (output valid, output sample_ch0, output sample_ch1, input ready);
	modport sink (input valid, input sample_ch0, input sample_ch1, output ready);
endinterface

interface tsb_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] out_ch0;
	logic signed [23:0] out_ch1;
	logic        [23:0] gain_now;
	logic               clipped;
	modport source (output valid, output out_ch0, output out_ch1, output gain_now,
		output clipped, input ready);
	modport sink (input valid, input out_ch0, input out_ch1, input gain_now,
		input clipped, output ready);
endinterface

interface tsb_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [23:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/tsb_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transient shaper band lane
// Fast and slow envelope followers of one channel, plus the output gain
// multiply and saturation of that channel.
// ----------------------------------------------------------------------------
module tsb_lane (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire tsb_pkg::tsb_ctrl_t      ctrl,
	input  wire                          active,
	input  wire signed [23:0]            sample,
	input  wire tsb_pkg::tsb_env_coef_t  fast_coef,
	input  wire tsb_pkg::tsb_env_coef_t  slow_coef,
	input  wire [23:0]                   gain,
	output logic [23:0]                  diff,
	output logic signed [23:0]           out_sample,
	output logic                         clip
);

	logic [23:0]        fast_env_q;
	logic [23:0]        slow_env_q;
	logic [23:0]        mag_q;
	logic signed [49:0] pf_q;
	logic signed [49:0] ps_q;
	logic signed [48:0] po_q;

	logic [23:0]        mag;
	logic [23:0]        fc;
	logic [23:0]        sc;
	logic signed [24:0] fdif;
	logic signed [24:0] sdif;
	logic signed [48:0] ro;
	logic [29:0]        rq;
	logic               fits;

	// mag + ((env - mag) * c + half) >>> 24, with mag folded back in
	function automatic logic [23:0] env_round(logic [23:0] m, logic signed [49:0] p);
		logic signed [49:0] r;
		logic [25:0]        s;
		r = p + 50'sd8388608;
		s = {2'b00, m} + r[49:24];
		return s[23:0];
	endfunction

	always_comb begin
		mag  = sample[23] ? (~sample + 24'd1) : sample;
		fc   = (mag > fast_env_q) ? fast_coef.atk : fast_coef.rls;
		sc   = (mag > slow_env_q) ? slow_coef.atk : slow_coef.rls;
		fdif = $signed({1'b0, fast_env_q}) - $signed({1'b0, mag});
		sdif = $signed({1'b0, slow_env_q}) - $signed({1'b0, mag});
	end

	always_ff @(posedge clk) begin
		if (ctrl.env_mul) begin
			mag_q <= mag;
			pf_q  <= fdif * $signed({1'b0, fc});
			ps_q  <= sdif * $signed({1'b0, sc});
		end
		if (ctrl.out_mul) begin
			po_q <= sample * $signed({1'b0, gain});
		end
	end

	// hold the envelopes of a lane that takes no part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_env_q <= '0;
			slow_env_q <= '0;
		end else if (ctrl.env_upd && active) begin
			fast_env_q <= env_round(mag_q, pf_q);
			slow_env_q <= env_round(mag_q, ps_q);
		end
	end

	always_comb begin
		diff = (fast_env_q > slow_env_q) ? (fast_env_q - slow_env_q) : '0;
		ro   = po_q + 49'sd262144;
		rq   = ro[48:19];
		fits = (&rq[29:23]) | ~(|rq[29:23]);
		if (!active) begin
			out_sample = '0;
			clip       = 1'b0;
		end else if (fits) begin
			out_sample = rq[23:0];
			clip       = 1'b0;
		end else begin
			out_sample = rq[29] ? tsb_pkg::SAMPLE_MIN : tsb_pkg::SAMPLE_MAX;
			clip       = 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/tsb_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transient shaper band merge
// Largest fast-minus-slow difference over the lanes in use.
// ----------------------------------------------------------------------------
module tsb_merge #(
	parameter int LANES = tsb_pkg::IN_LANES
) (
	input  wire                        clk,
	input  wire tsb_pkg::tsb_ctrl_t    ctrl,
	input  wire [LANES-1:0]            active,
	input  wire [LANES-1:0][23:0]      diff,
	output logic [23:0]                t
);

	logic [23:0] t_q;
	logic [23:0] best;

	always_comb begin
		best = '0;
		for (int i = 0; i < LANES; i++) begin
			if (active[i] && (diff[i] > best)) begin
				best = diff[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.t_load) begin
			t_q <= best;
		end
	end

	assign t = t_q;

endmodule
`default_nettype wire

FILE: rtl/tsb_gain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transient shaper band gain path
// Mix transient and sustain gains by the transient amount, form the target
// and smooth it into the kept gain.
// ----------------------------------------------------------------------------
module tsb_gain (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire tsb_pkg::tsb_ctrl_t  ctrl,
	input  wire [23:0]               t,
	input  wire [23:0]               peak_gain,
	input  wire [23:0]               body_gain,
	input  wire [23:0]               smoothing_coef,
	output logic [23:0]              gain
);

	logic [23:0] tv_q;
	logic [23:0] sv_q;
	logic [23:0] target_q;
	logic [23:0] gain_q;

	logic [23:0]        u;
	logic signed [24:0] dt;
	logic signed [24:0] ds;
	logic signed [49:0] rt;
	logic signed [49:0] rs;
	logic [26:0]        tv;
	logic [26:0]        sv;
	logic [48:0]        rp;
	logic signed [24:0] dg;
	logic signed [49:0] rg;
	logic [25:0]        gn;

	always_comb begin
		u  = tsb_pkg::HALF_SCALE - t;
		dt = $signed({1'b0, peak_gain}) - $signed({1'b0, tsb_pkg::UNITY_GAIN});
		ds = $signed({1'b0, body_gain}) - $signed({1'b0, tsb_pkg::UNITY_GAIN});
		rt = dt * $signed({1'b0, t}) + 50'sd4194304;
		rs = ds * $signed({1'b0, u}) + 50'sd4194304;
		tv = {3'b000, tsb_pkg::UNITY_GAIN} + rt[49:23];
		sv = {3'b000, tsb_pkg::UNITY_GAIN} + rs[49:23];
		rp = 49'(tv_q) * 49'(sv_q) + 49'd262144;
		dg = $signed({1'b0, gain_q}) - $signed({1'b0, target_q});
		rg = dg * $signed({1'b0, smoothing_coef}) + 50'sd8388608;
		gn = {2'b00, target_q} + rg[49:24];
	end

	always_ff @(posedge clk) begin
		if (ctrl.mix) begin
			tv_q <= tv[23:0];
			sv_q <= sv[23:0];
		end
		if (ctrl.tgt) begin
			target_q <= (|rp[48:43]) ? tsb_pkg::GAIN_MAX : rp[42:19];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= tsb_pkg::UNITY_GAIN;
		end else if (ctrl.smooth) begin
			gain_q <= gn[23:0];
		end
	end

	assign gain = gain_q;

endmodule
`default_nettype wire

FILE: rtl/transient_shaper_band_unit.sv
// A result word is offered once its input word has passed every step of the single
// sequencer that walks each frame through the envelope, gain and output steps; a new
// input word is taken only in idle, once the last frame is through those steps.
// A result left waiting stalls the sequencer in its last step.
// Reset (arst_n low, asynchronous): envelopes clear, kept gain goes to unity,
// registers return to their defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transient shaper band unit
// Per-channel fast/slow envelope lanes, a merge of their differences into a
// transient amount, a gain path that shapes and smooths the gain, and a
// gained, saturated output word per frame.
// ----------------------------------------------------------------------------
module transient_shaper_band_unit #(
	parameter int CHANNELS = tsb_pkg::CHANNELS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	tsb_in_if.sink      in_bus,
	tsb_out_if.source   out_bus,
	tsb_cfg_if.sink     cfg_bus
);

	// lanes actually built: the frame carries two samples at most
	localparam int LANES = (CHANNELS < tsb_pkg::IN_LANES) ? CHANNELS : tsb_pkg::IN_LANES;

	// ------------------------------------------------------------------
	// Configuration registers; writes are taken at any time
	// ------------------------------------------------------------------
	logic [1:0]  ch_use_q;
	logic [23:0] tgain_q;
	logic [23:0] sgain_q;
	logic [23:0] fatk_q;
	logic [23:0] frls_q;
	logic [23:0] satk_q;
	logic [23:0] srls_q;
	logic [23:0] smooth_q;

	assign cfg_bus.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_use_q <= 2'd2;
			tgain_q  <= tsb_pkg::UNITY_GAIN;
			sgain_q  <= tsb_pkg::UNITY_GAIN;
			fatk_q   <= '0;
			frls_q   <= '0;
			satk_q   <= '0;
			srls_q   <= '0;
			smooth_q <= '0;
		end else if (cfg_bus.valid) begin
			case (tsb_pkg::tsb_reg_t'(cfg_bus.index))
				tsb_pkg::REG_CHANNELS_IN_USE:   ch_use_q <= cfg_bus.data[1:0];
				tsb_pkg::REG_TRANSIENT_GAIN:    tgain_q  <= cfg_bus.data;
				tsb_pkg::REG_SUSTAIN_GAIN:      sgain_q  <= cfg_bus.data;
				tsb_pkg::REG_FAST_ATTACK_COEF:  fatk_q   <= cfg_bus.data;
				tsb_pkg::REG_FAST_RELEASE_COEF: frls_q   <= cfg_bus.data;
				tsb_pkg::REG_SLOW_ATTACK_COEF:  satk_q   <= cfg_bus.data;
				tsb_pkg::REG_SLOW_RELEASE_COEF: srls_q   <= cfg_bus.data;
				tsb_pkg::REG_SMOOTHING_COEF:    smooth_q <= cfg_bus.data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer: one frame at a time through the shared steps
	// ------------------------------------------------------------------
	tsb_pkg::tsb_state_t state_q;
	tsb_pkg::tsb_state_t state_d;
	tsb_pkg::tsb_ctrl_t  ctrl;
	logic                out_load;
	logic                in_take;
	logic                out_valid_q;

	assign in_bus.ready = (state_q == tsb_pkg::ST_IDLE);
	assign in_take      = in_bus.valid && in_bus.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		out_load = 1'b0;
		case (state_q)
			tsb_pkg::ST_IDLE: begin
				if (in_bus.valid) begin
					state_d = tsb_pkg::ST_ENV_MUL;
				end
			end
			tsb_pkg::ST_ENV_MUL: begin
				ctrl.env_mul = 1'b1;
				state_d      = tsb_pkg::ST_ENV_UPD;
			end
			tsb_pkg::ST_ENV_UPD: begin
				ctrl.env_upd = 1'b1;
				state_d      = tsb_pkg::ST_MAX;
			end
			tsb_pkg::ST_MAX: begin
				ctrl.t_load = 1'b1;
				state_d     = tsb_pkg::ST_MIX;
			end
			tsb_pkg::ST_MIX: begin
				ctrl.mix = 1'b1;
				state_d  = tsb_pkg::ST_TGT;
			end
			tsb_pkg::ST_TGT: begin
				ctrl.tgt = 1'b1;
				state_d  = tsb_pkg::ST_SMOOTH;
			end
			tsb_pkg::ST_SMOOTH: begin
				ctrl.smooth = 1'b1;
				state_d     = tsb_pkg::ST_OUT_MUL;
			end
			tsb_pkg::ST_OUT_MUL: begin
				ctrl.out_mul = 1'b1;
				state_d      = tsb_pkg::ST_OUT_SAT;
			end
			tsb_pkg::ST_OUT_SAT: begin
				// hold here until the result register is free or being drained
				if (!out_valid_q || out_bus.ready) begin
					out_load = 1'b1;
					state_d  = tsb_pkg::ST_IDLE;
				end
			end
			default: state_d = tsb_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Frame capture: samples and the lanes in use for this frame
	// ------------------------------------------------------------------
	logic signed [23:0] sample_q [tsb_pkg::IN_LANES];
	logic [LANES-1:0]   act_q;

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q[0] <= in_bus.sample_ch0;
			sample_q[1] <= in_bus.sample_ch1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
		end else if (in_take) begin
			for (int i = 0; i < LANES; i++) begin
				act_q[i] <= (ch_use_q > 2'(i));
			end
		end
	end

	// ------------------------------------------------------------------
	// Lanes, merge and gain path
	// ------------------------------------------------------------------
	tsb_pkg::tsb_env_coef_t          fast_coef;
	tsb_pkg::tsb_env_coef_t          slow_coef;
	logic [LANES-1:0][23:0]          lane_diff;
	logic signed [23:0]              lane_out  [tsb_pkg::IN_LANES];
	logic [tsb_pkg::IN_LANES-1:0]    lane_clip;
	logic [23:0]                     t;
	logic [23:0]                     gain;

	assign fast_coef = '{atk: fatk_q, rls: frls_q};
	assign slow_coef = '{atk: satk_q, rls: srls_q};

	for (genvar gi = 0; gi < tsb_pkg::IN_LANES; gi++) begin : g_lane
		if (gi < LANES) begin : g_built
			tsb_lane u_lane (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.active     (act_q[gi]),
				.sample     (sample_q[gi]),
				.fast_coef  (fast_coef),
				.slow_coef  (slow_coef),
				.gain       (gain),
				.diff       (lane_diff[gi]),
				.out_sample (lane_out[gi]),
				.clip       (lane_clip[gi])
			);
		end else begin : g_absent
			// lane not built: its output word is zero and never clips
			assign lane_out[gi]  = '0;
			assign lane_clip[gi] = 1'b0;
		end
	end

	tsb_merge #(
		.LANES (LANES)
	) u_merge (
		.clk    (clk),
		.ctrl   (ctrl),
		.active (act_q),
		.diff   (lane_diff),
		.t      (t)
	);

	tsb_gain u_gain (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.t              (t),
		.peak_gain      (tgain_q),
		.body_gain      (sgain_q),
		.smoothing_coef (smooth_q),
		.gain           (gain)
	);

	// ------------------------------------------------------------------
	// Result register: parts the output side from the sequencer
	// ------------------------------------------------------------------
	logic signed [23:0] out0_q;
	logic signed [23:0] out1_q;
	logic [23:0]        gain_out_q;
	logic               clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_bus.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out0_q     <= lane_out[0];
			out1_q     <= lane_out[1];
			gain_out_q <= gain;
			clip_q     <= |lane_clip;
		end
	end

	assign out_bus.valid    = out_valid_q;
	assign out_bus.out_ch0  = out0_q;
	assign out_bus.out_ch1  = out1_q;
	assign out_bus.gain_now = gain_out_q;
	assign out_bus.clipped  = clip_q;

`ifndef SYNTHESIS
	// a taken frame starts the envelope step at once
	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == tsb_pkg::ST_ENV_MUL))
		else $error("frame taken but envelope step not started");

	// a result word appears only from the final step
	a_load_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == tsb_pkg::ST_OUT_SAT))
		else $error("result word raised outside the final step");

	// a clip flag implies one of the samples sits on a rail
	a_clip_on_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && clip_q) |->
			(out0_q == tsb_pkg::SAMPLE_MAX || out0_q == tsb_pkg::SAMPLE_MIN ||
			 out1_q == tsb_pkg::SAMPLE_MAX || out1_q == tsb_pkg::SAMPLE_MIN))
		else $error("clip flagged with no saturated sample");
`endif

endmodule
`default_nettype wire
